@@ rtl/core/ascii85_stream_decoder_top_macros.svh @@
// ----------------------------------------------------------------------------
// ascii85 stream decoder assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASCII85_STREAM_DECODER_TOP_MACROS_SVH
`define ASCII85_STREAM_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define A85_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("a85 assertion failed");

// next-cycle implication
`define A85_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("a85 assertion failed");

`else

`define A85_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define A85_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/core/a85_pkg.sv @@
// ----------------------------------------------------------------------------
// a85_pkg
// types, codes and helper functions for the ascii85 stream decoder
// ----------------------------------------------------------------------------
package a85_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // characters
  localparam logic [7:0] CH_FIRST_DIGIT = 8'h21;  // '!'
  localparam logic [7:0] CH_LAST_DIGIT  = 8'h75;  // 'u'
  localparam logic [7:0] CH_ZERO_GROUP  = 8'h7A;  // 'z'
  localparam logic [7:0] CH_TILDE       = 8'h7E;  // '~'
  localparam logic [7:0] CH_GT          = 8'h3E;  // '>'
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_TAB         = 8'h09;
  localparam logic [7:0] CH_CR          = 8'h0D;

  localparam logic [19:0] BASE      = 20'd85;
  localparam logic [19:0] BASE_POW2 = 20'd7225;
  localparam logic [19:0] BASE_POW3 = 20'd614125;

  // everything one input item produces, at most four bytes then a status
  typedef struct packed {
    logic [31:0] word;        // bytes, most significant first
    logic [2:0]  nbytes;      // 0..4
    logic        has_status;
    logic [1:0]  status_kind;
    logic [31:0] base_count;  // byte count before this item
  } a85_bundle_t;

  // multiplier that pads a partial group out to five digits
  function automatic logic [19:0] pad_factor(input logic [2:0] digits);
    logic [19:0] f;
    case (digits)
      3'd2:    f = BASE_POW3;
      3'd3:    f = BASE_POW2;
      default: f = BASE;
    endcase
    return f;
  endfunction

  // rounding term for a partial group
  function automatic logic [31:0] pad_fill(input logic [2:0] digits);
    logic [31:0] f;
    case (digits)
      3'd2:    f = 32'h00FF_FFFF;
      3'd3:    f = 32'h0000_FFFF;
      3'd4:    f = 32'h0000_00FF;
      default: f = 32'h0000_0000;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [2:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ rtl/core/a85_ifs.sv @@
// ----------------------------------------------------------------------------
// a85 channel interfaces
// valid/ready channels for text bytes in and decoded results out
// ----------------------------------------------------------------------------
interface a85_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_buffer;

  modport source (output valid, output text_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input text_byte, input end_of_buffer, output ready);
endinterface

interface a85_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  decoded_byte;
  logic [31:0] bytes_total;
  logic        last_of_run;

  modport source (output valid, output result_kind, output decoded_byte,
                  output bytes_total, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input decoded_byte,
                  input bytes_total, input last_of_run, output ready);
endinterface

@@ rtl/core/a85_decode.sv @@
// ----------------------------------------------------------------------------
// a85_decode
// input register, stream state and per-character decode into a result bundle
// ----------------------------------------------------------------------------
module a85_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_end_of_buffer,
  input  logic                 bundle_free,
  output logic                 bundle_valid,
  output a85_pkg::a85_bundle_t bundle
);
  import a85_pkg::*;

  logic        iv_r;
  logic [7:0]  ib_r;
  logic        ie_r;
  logic        advance;

  logic [31:0] sum_r, sum_nxt;
  logic [2:0]  dc_r, dc_nxt;
  logic        tp_r, tp_nxt;
  logic        stop_r, stop_nxt;
  logic [31:0] cnt_r, cnt_nxt;

  logic        is_digit;
  logic        is_blank;
  logic [7:0]  digit;
  logic [19:0] mul_k;
  logic [31:0] prod;
  logic [31:0] addend;
  logic [31:0] acc;
  logic        ended;
  logic        clear;
  logic [31:0] word;
  logic [2:0]  nb;
  logic        has_st;
  logic [1:0]  st_kind;

  assign advance  = iv_r && bundle_free;
  assign in_ready = !iv_r || bundle_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_ready) begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ib_r <= in_text_byte;
      ie_r <= in_end_of_buffer;
    end
  end

  assign is_digit = (ib_r >= CH_FIRST_DIGIT) && (ib_r <= CH_LAST_DIGIT);
  assign is_blank = (ib_r == CH_SPACE) || ((ib_r >= CH_TAB) && (ib_r <= CH_CR));
  assign digit    = ib_r - CH_FIRST_DIGIT;

  // one shared constant multiply: next digit, or padding at the end marker
  assign mul_k  = tp_r ? pad_factor(dc_r) : BASE;
  assign prod   = sum_r * {12'd0, mul_k};
  assign addend = tp_r ? pad_fill(dc_r) : {24'd0, digit};
  assign acc    = prod + addend;

  always_comb begin
    sum_nxt  = sum_r;
    dc_nxt   = dc_r;
    tp_nxt   = tp_r;
    stop_nxt = stop_r;
    ended    = 1'b0;
    clear    = 1'b0;
    word     = 32'd0;
    nb       = 3'd0;
    has_st   = 1'b0;
    st_kind  = KIND_OK;
    if (stop_r) begin
      clear = ie_r;
    end else begin
      if (tp_r) begin
        tp_nxt = 1'b0;
        ended  = 1'b1;
        has_st = 1'b1;
        if ((ib_r != CH_GT) || (dc_r == 3'd1)) begin
          st_kind = KIND_ERR;
        end else if (dc_r >= 3'd2) begin
          word = acc;
          nb   = dc_r - 3'd1;
        end
      end else if (is_digit) begin
        if (dc_r == 3'd4) begin
          word    = acc;
          nb      = 3'd4;
          sum_nxt = 32'd0;
          dc_nxt  = 3'd0;
        end else begin
          sum_nxt = acc;
          dc_nxt  = dc_r + 3'd1;
        end
      end else if (ib_r == CH_ZERO_GROUP) begin
        if (dc_r != 3'd0) begin
          ended   = 1'b1;
          has_st  = 1'b1;
          st_kind = KIND_ERR;
        end else begin
          nb = 3'd4;
        end
      end else if (ib_r == CH_TILDE) begin
        if (ie_r) begin
          ended   = 1'b1;
          has_st  = 1'b1;
          st_kind = KIND_ERR;
        end else begin
          tp_nxt = 1'b1;
        end
      end else if (!is_blank) begin
        ended   = 1'b1;
        has_st  = 1'b1;
        st_kind = KIND_ERR;
      end
      if (ended) begin
        stop_nxt = 1'b1;
      end
      if (ie_r) begin
        clear = 1'b1;
        if (!ended) begin
          has_st  = 1'b1;
          st_kind = KIND_OK;
        end
      end
    end
    cnt_nxt = sat_add(cnt_r, nb);
    if (clear) begin
      sum_nxt  = 32'd0;
      dc_nxt   = 3'd0;
      tp_nxt   = 1'b0;
      stop_nxt = 1'b0;
      cnt_nxt  = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= 32'd0;
      dc_r   <= 3'd0;
      tp_r   <= 1'b0;
      stop_r <= 1'b0;
      cnt_r  <= 32'd0;
    end else if (advance) begin
      sum_r  <= sum_nxt;
      dc_r   <= dc_nxt;
      tp_r   <= tp_nxt;
      stop_r <= stop_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign bundle_valid       = advance && ((nb != 3'd0) || has_st);
  assign bundle.word        = word;
  assign bundle.nbytes      = nb;
  assign bundle.has_status  = has_st;
  assign bundle.status_kind = st_kind;
  assign bundle.base_count  = cnt_r;

endmodule

@@ rtl/core/a85_emit.sv @@
// ----------------------------------------------------------------------------
// a85_emit
// result register holds one bundle; hands out results, if ready, one per cycle
// ----------------------------------------------------------------------------
module a85_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 bundle_valid,
  input  a85_pkg::a85_bundle_t bundle,
  output logic                 bundle_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_result_kind,
  output logic [7:0]           out_decoded_byte,
  output logic [31:0]          out_bytes_total,
  output logic                 out_last_of_run
);
  import a85_pkg::*;

  logic        bv_r;
  a85_bundle_t b_r;
  logic [2:0]  idx_r;
  logic [31:0] cnt_r;

  logic        is_data;
  logic        last;
  logic        fire;
  logic [2:0]  total;
  logic [31:0] shifted;

  assign total   = b_r.nbytes + {2'd0, b_r.has_status};
  assign is_data = idx_r < b_r.nbytes;
  assign last    = (idx_r + 3'd1) == total;
  assign fire    = bv_r && out_ready;

  assign bundle_free = !bv_r || (fire && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= 1'b0;
    end else if (bundle_free) begin
      bv_r <= bundle_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle_free && bundle_valid) begin
      b_r   <= bundle;
      idx_r <= 3'd0;
      cnt_r <= bundle.base_count;
    end else if (fire) begin
      idx_r <= idx_r + 3'd1;
      if (is_data) begin
        cnt_r <= sat_add(cnt_r, 3'd1);
      end
    end
  end

  // byte idx of the word, most significant first
  assign shifted = b_r.word << {idx_r[1:0], 3'b000};

  assign out_valid        = bv_r;
  assign out_result_kind  = is_data ? KIND_BYTE : b_r.status_kind;
  assign out_decoded_byte = is_data ? shifted[31:24] : 8'd0;
  assign out_bytes_total  = is_data ? sat_add(cnt_r, 3'd1) : cnt_r;
  assign out_last_of_run  = last;

endmodule

@@ rtl/core/ascii85_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// ascii85_stream_decoder_top
// ascii85 text stream decoder with per-stream status and byte count
// ----------------------------------------------------------------------------
// One text byte is taken per item and decoded while it sits in the input
// register; the results it causes (zero to five: up to four decoded bytes,
// then a status at the end of a stream) sit in the result register and
// leave one per cycle on the result channel while the receiver is ready.
// Items are taken one per cycle while each causes at most one result and the
// receiver is ready; an item with more results holds the result register
// until its last result leaves, so the output port sets the rate. The first
// result of an item is valid once through the input and result registers.
`include "ascii85_stream_decoder_top_macros.svh"

module ascii85_stream_decoder_top (
  input  logic          clk,
  input  logic          rst_n,
  a85_in_if.sink        in_ch,
  a85_out_if.source     out_ch
);
  import a85_pkg::*;

  logic        bundle_valid;
  logic        bundle_free;
  a85_bundle_t bundle;

  a85_decode u_decode (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_text_byte     (in_ch.text_byte),
    .in_end_of_buffer (in_ch.end_of_buffer),
    .bundle_free      (bundle_free),
    .bundle_valid     (bundle_valid),
    .bundle           (bundle)
  );

  a85_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .bundle_valid     (bundle_valid),
    .bundle           (bundle),
    .bundle_free      (bundle_free),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_result_kind  (out_ch.result_kind),
    .out_decoded_byte (out_ch.decoded_byte),
    .out_bytes_total  (out_ch.bytes_total),
    .out_last_of_run  (out_ch.last_of_run)
  );

  // a status always closes the run of results for its item
  `A85_ASSERT_IMP(a_status_last, clk, rst_n,
    out_ch.valid && (out_ch.result_kind != KIND_BYTE), out_ch.last_of_run)

  // every decoded byte is counted
  `A85_ASSERT_IMP(a_byte_counted, clk, rst_n,
    out_ch.valid && (out_ch.result_kind == KIND_BYTE), out_ch.bytes_total != 32'd0)

  // a new bundle is only handed over when the result register can take it
  `A85_ASSERT_NXT(a_bundle_loaded, clk, rst_n,
    bundle_valid && bundle_free, out_ch.valid)

endmodule

@@ sim/ascii85_stream_decoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// ascii85_stream_decoder_top_tb
// drives text streams into the ascii85 decoder and checks each decoded byte
// and stream status against a local decoder model, under random stalls
// ----------------------------------------------------------------------------
module ascii85_stream_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import a85_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 80;
  localparam int LIVE_TARGET    = 410;
  localparam int CALM_FROM      = 350;
  localparam int PRESSURE_AT    = 150;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] total;
    logic        last;
  } decode_result_t;

  typedef struct packed {
    logic [7:0]  chr;
    logic        eob;
    logic        typed;
    logic [1:0]  kind;
    logic [31:0] total;
  } text_row_t;

  logic clk;
  logic rst_n;

  a85_in_if  text_ch ();
  a85_out_if result_ch ();

  ascii85_stream_decoder_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (text_ch),
    .out_ch (result_ch)
  );

  // decoder model state
  logic [31:0] group_acc;
  logic [2:0]  group_digits;
  logic        tilde_seen;
  logic        halted;
  logic [31:0] bytes_emitted;

  decode_result_t owed_results [$];

  int  fail_count    = 0;
  int  live_items    = 0;
  bit  idle_on       = 1'b1;
  bit  hold_req      = 1'b0;
  bit  pressure_done = 1'b0;

  // directed rows: typed ones produce exactly one status item
  text_row_t directed_rows [0:26] = '{
    '{CH_SPACE,       1'b1, 1'b1, KIND_OK,   32'd0},
    '{8'h00,          1'b0, 1'b1, KIND_ERR,  32'd0},
    '{8'hFF,          1'b1, 1'b0, KIND_BYTE, 32'd0},
    '{CH_LAST_DIGIT,  1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_LAST_DIGIT,  1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_LAST_DIGIT,  1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_LAST_DIGIT,  1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_LAST_DIGIT,  1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_ZERO_GROUP,  1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_TAB,         1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_CR,          1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_FIRST_DIGIT, 1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_TILDE,       1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_GT,          1'b0, 1'b1, KIND_ERR,  32'd8},
    '{8'h41,          1'b1, 1'b0, KIND_BYTE, 32'd0},
    '{CH_FIRST_DIGIT, 1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_FIRST_DIGIT, 1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_TILDE,       1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_GT,          1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{8'h71,          1'b1, 1'b0, KIND_BYTE, 32'd0},
    '{CH_FIRST_DIGIT, 1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{CH_ZERO_GROUP,  1'b0, 1'b1, KIND_ERR,  32'd0},
    '{CH_TILDE,       1'b1, 1'b0, KIND_BYTE, 32'd0},
    '{CH_TILDE,       1'b1, 1'b1, KIND_ERR,  32'd0},
    '{CH_TILDE,       1'b0, 1'b0, KIND_BYTE, 32'd0},
    '{8'h61,          1'b0, 1'b1, KIND_ERR,  32'd0},
    '{8'hFF,          1'b1, 1'b0, KIND_BYTE, 32'd0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic clear_decoder();
    group_acc     = '0;
    group_digits  = '0;
    tilde_seen    = 1'b0;
    halted        = 1'b0;
    bytes_emitted = '0;
  endtask

  task automatic owe_result(input logic [1:0] kind, input logic [7:0] data);
    if (kind == KIND_BYTE && bytes_emitted != 32'hFFFF_FFFF) begin
      bytes_emitted = bytes_emitted + 32'd1;
    end
    owed_results.push_back('{kind, (kind == KIND_BYTE) ? data : 8'h00, bytes_emitted, 1'b0});
  endtask

  // results that one text byte causes, appended to owed_results
  task automatic decode_char(input logic [7:0] c, input logic eob);
    logic        ended;
    logic [31:0] padded;
    int          first;
    int          k;
    ended = 1'b0;
    first = owed_results.size();
    if (halted) begin
      if (eob) begin
        clear_decoder();
      end
      return;
    end
    if (tilde_seen) begin
      tilde_seen = 1'b0;
      ended = 1'b1;
      if (c != CH_GT || group_digits == 3'd1) begin
        owe_result(KIND_ERR, 8'h00);
      end else begin
        if (group_digits >= 3'd2) begin
          padded = group_acc;
          for (k = int'(group_digits); k < 5; k++) padded = padded * 32'd85;
          padded = padded + (32'h00FF_FFFF >> (8 * (int'(group_digits) - 2)));
          for (k = 0; k < int'(group_digits) - 1; k++) begin
            owe_result(KIND_BYTE, 8'(padded >> (24 - 8 * k)));
          end
        end
        owe_result(KIND_OK, 8'h00);
      end
    end else if (c >= CH_FIRST_DIGIT && c <= CH_LAST_DIGIT) begin
      group_acc = group_acc * 32'd85 + 32'(c - CH_FIRST_DIGIT);
      group_digits = group_digits + 3'd1;
      if (group_digits >= 3'd5) begin
        for (k = 0; k < 4; k++) owe_result(KIND_BYTE, 8'(group_acc >> (24 - 8 * k)));
        group_digits = '0;
        group_acc = '0;
      end
    end else if (c == CH_ZERO_GROUP) begin
      if (group_digits != 3'd0) begin
        owe_result(KIND_ERR, 8'h00);
        ended = 1'b1;
      end else begin
        for (k = 0; k < 4; k++) owe_result(KIND_BYTE, 8'h00);
      end
    end else if (c == CH_TILDE) begin
      if (eob) begin
        owe_result(KIND_ERR, 8'h00);
        ended = 1'b1;
      end else begin
        tilde_seen = 1'b1;
      end
    end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
      owe_result(KIND_ERR, 8'h00);
      ended = 1'b1;
    end
    if (ended) begin
      halted = 1'b1;
    end
    if (eob) begin
      if (!ended) begin
        owe_result(KIND_OK, 8'h00);
      end
      clear_decoder();
    end
    if (owed_results.size() > first) begin
      owed_results[owed_results.size() - 1].last = 1'b1;
    end
  endtask

  // offer one item, wait for it to be taken, then update the model
  task automatic send_item(input logic [7:0] c, input logic eob,
                           input logic typed = 1'b0,
                           input logic [1:0] kind = KIND_BYTE,
                           input logic [31:0] total = '0);
    int qlen;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    text_ch.valid         <= 1'b1;
    text_ch.text_byte     <= c;
    text_ch.end_of_buffer <= eob;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    live_items++;
    qlen = owed_results.size();
    decode_char(c, eob);
    if (typed) begin
      while (owed_results.size() > qlen) void'(owed_results.pop_back());
      owed_results.push_back('{kind, 8'h00, total, 1'b1});
    end
  endtask

  function automatic logic [7:0] rand_digit();
    case ($urandom_range(0, 7))
      0, 1:    return CH_LAST_DIGIT;
      2:       return CH_FIRST_DIGIT;
      default: return 8'($urandom_range(CH_FIRST_DIGIT, CH_LAST_DIGIT));
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
  endfunction

  task automatic send_digits(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 5) == 0) begin
        send_item(rand_blank(), 1'b0);
      end
      send_item(rand_digit(), 1'b0);
    end
  endtask

  // sender
  initial begin
    int k;
    int ngroups;
    int nbytes;
    logic [7:0] c;
    rst_n                 <= 1'b0;
    text_ch.valid         <= 1'b0;
    text_ch.text_byte     <= 8'h00;
    text_ch.end_of_buffer <= 1'b0;
    clear_decoder();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].chr, directed_rows[i].eob, directed_rows[i].typed,
                directed_rows[i].kind, directed_rows[i].total);
    end

    while (live_items < LIVE_TARGET) begin
      if (live_items >= CALM_FROM) begin
        idle_on = 1'b0;
      end else begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (!pressure_done && live_items >= PRESSURE_AT) begin
        hold_req = 1'b1;
        pressure_done = 1'b1;
      end
      if ($urandom_range(0, 4) != 0) begin
        // well-formed stream with random content
        ngroups = $urandom_range(0, 4);
        for (k = 0; k < ngroups; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_item(CH_ZERO_GROUP, 1'b0);
          end else begin
            send_digits(5);
          end
        end
        send_digits($urandom_range(0, 4));
        case ($urandom_range(0, 2))
          0: begin
            send_item($urandom_range(0, 1) ? rand_digit() : rand_blank(), 1'b1);
          end
          1: begin
            send_item(CH_TILDE, 1'b0);
            send_item(CH_GT, 1'b1);
          end
          default: begin
            send_item(CH_TILDE, 1'b0);
            send_item(CH_GT, 1'b0);
            repeat ($urandom_range(0, 2)) send_item(8'($urandom_range(0, 255)), 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
          end
        endcase
      end else begin
        // noise and broken sequences
        nbytes = $urandom_range(1, 8);
        for (k = 0; k < nbytes; k++) begin
          case ($urandom_range(0, 5))
            0, 1:    c = 8'($urandom_range(0, 255));
            2:       c = rand_digit();
            3:       c = CH_ZERO_GROUP;
            4:       c = CH_TILDE;
            default: c = CH_GT;
          endcase
          send_item(c, k == nbytes - 1);
        end
      end
    end
    text_ch.valid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver stalls, plus one long hold-off so the block backs up
  initial begin
    int sink_gap;
    sink_gap = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (idle_on && sink_gap == 0 && $urandom_range(0, 7) == 0) begin
          sink_gap = $urandom_range(1, 7);
        end
        if (sink_gap > 0) begin
          result_ch.ready <= 1'b0;
          sink_gap--;
        end else begin
          result_ch.ready <= 1'b1;
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    decode_result_t got;
    decode_result_t want;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      got = '{result_ch.result_kind, result_ch.decoded_byte,
              result_ch.bytes_total, result_ch.last_of_run};
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected item kind %0d byte %02h total %0d last %0b",
                 $time, got.kind, got.data, got.total, got.last);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch exp kind %0d byte %02h total %0d last %0b",
                   $time, want.kind, want.data, want.total, want.last);
          $display("%0t:          got kind %0d byte %02h total %0d last %0b",
                   $time, got.kind, got.data, got.total, got.last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
